// ----- hw/rtl/dtda_pkg.sv -----
// shared types, constants and calendar helpers of the date and time adder
package dtda_pkg;

  localparam int unsigned YEAR_W = 16;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned ADDD_W = 16;
  localparam int unsigned ADDS_W = 32;

  // reciprocal-multiply divider: dividend, multiplier operands, quotient, phase
  localparam int unsigned DVD_W   = 33;
  localparam int unsigned MUL_A_W = 31;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned QUO_W   = 27;
  localparam int unsigned CNT_W   = 1;
  localparam logic [CNT_W-1:0] LAST_PHASE = 1'b1;

  // x / 400 = (x >> 4) / 25, x / 60 = (x >> 2) / 15, x / 24 = (x >> 3) / 3
  localparam logic [MUL_B_W-1:0] RECIP_25 = 32'd2622;        // 2^16 / 25 rounded up
  localparam logic [MUL_B_W-1:0] RECIP_15 = 32'd2290649225;  // 2^35 / 15 rounded up
  localparam logic [MUL_B_W-1:0] RECIP_3  = 32'd349526;      // 2^20 / 3 rounded up
  localparam int unsigned SHIFT_25 = 16;
  localparam int unsigned SHIFT_15 = 35;
  localparam int unsigned SHIFT_3  = 20;

  // year modulo 400
  localparam int unsigned YMOD_W = 9;

  // remaining day count: add_days plus at most about 49711 carried days
  localparam int unsigned REM_W = 17;

  localparam logic [YMOD_W-1:0] CENTURY_1   = 9'd100;
  localparam logic [YMOD_W-1:0] CENTURY_2   = 9'd200;
  localparam logic [YMOD_W-1:0] CENTURY_3   = 9'd300;
  localparam logic [YMOD_W-1:0] YMOD_LAST   = 9'd399;

  localparam logic [MON_W-1:0]  MON_JAN = 4'd1;
  localparam logic [MON_W-1:0]  MON_FEB = 4'd2;
  localparam logic [MON_W-1:0]  MON_APR = 4'd4;
  localparam logic [MON_W-1:0]  MON_JUN = 4'd6;
  localparam logic [MON_W-1:0]  MON_SEP = 4'd9;
  localparam logic [MON_W-1:0]  MON_NOV = 4'd11;
  localparam logic [MON_W-1:0]  MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0]  LEN_31 = 5'd31;
  localparam logic [DAY_W-1:0]  LEN_30 = 5'd30;
  localparam logic [DAY_W-1:0]  LEN_29 = 5'd29;
  localparam logic [DAY_W-1:0]  LEN_28 = 5'd28;
  localparam logic [8:0]        YLEN_LEAP = 9'd366;
  localparam logic [8:0]        YLEN_NORM = 9'd365;

  localparam logic [HOUR_W-1:0] LAST_HOUR = 5'd23;
  localparam logic [MIN_W-1:0]  LAST_MIN  = 6'd59;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YMOD,
    ST_CHECK,
    ST_SEC,
    ST_MIN,
    ST_HR,
    ST_PART,
    ST_YEAR,
    ST_MONTH,
    ST_FINAL,
    ST_EMIT
  } dtda_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_MUL,
    OP_SET_YMOD,
    OP_START_SEC,
    OP_NEXT_MIN,
    OP_NEXT_HR,
    OP_FIN_HR,
    OP_PARTIAL,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_FINAL,
    OP_OUTPUT
  } dtda_op_t;

  typedef enum logic [1:0] {
    DIV_400,
    DIV_60,
    DIV_24
  } dtda_div_t;

  typedef struct packed {
    dtda_op_t  op;
    dtda_div_t dsel;
  } dtda_cmd_t;

  typedef struct packed {
    logic bad;
    logic year_done;
    logic month_done;
  } dtda_stat_t;

  // leap test on the year modulo 400
  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    logic century;
    century = (ymod == CENTURY_1) || (ymod == CENTURY_2) || (ymod == CENTURY_3);
    return (ymod == '0) || (!century && (ymod[1:0] == 2'b00));
  endfunction

  // month length, 31 for codes that are no month
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m) inside
      MON_FEB: len = leap ? LEN_29 : LEN_28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
      default: len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/dtda_dpath.sv -----
// datapath: working registers, reciprocal-multiply divider, calendar stepping, result register
module dtda_dpath import dtda_pkg::*; #(
  parameter int unsigned DAYS_BITS = 16
) (
  input  logic              clk,
  input  dtda_cmd_t         cmd,
  output dtda_stat_t        stat,
  input  logic [YEAR_W-1:0] start_year,
  input  logic [MON_W-1:0]  start_month,
  input  logic [DAY_W-1:0]  start_day,
  input  logic [HOUR_W-1:0] start_hour,
  input  logic [MIN_W-1:0]  start_minute,
  input  logic [SEC_W-1:0]  start_second,
  input  logic [ADDD_W-1:0] add_days,
  input  logic [ADDS_W-1:0] add_seconds,
  output logic [YEAR_W-1:0] new_year,
  output logic [MON_W-1:0]  new_month,
  output logic [DAY_W-1:0]  new_day,
  output logic [HOUR_W-1:0] new_hour,
  output logic [MIN_W-1:0]  new_minute,
  output logic [SEC_W-1:0]  new_second,
  output logic              bad_input
);

  localparam int unsigned KEEP_BITS = (DAYS_BITS < ADDD_W) ? DAYS_BITS : ADDD_W;
  localparam logic [ADDD_W-1:0] DAYS_MASK =
    ADDD_W'(({{ADDD_W{1'b0}}, 1'b1} << KEEP_BITS) - 1'b1);

  logic [YEAR_W-1:0] y;
  logic [MON_W-1:0]  m;
  logic [DAY_W-1:0]  d;
  logic [HOUR_W-1:0] hh;
  logic [MIN_W-1:0]  mi;
  logic [SEC_W-1:0]  ss;
  logic [ADDD_W-1:0] days;
  logic [ADDS_W-1:0] secs;
  logic [YMOD_W-1:0] ymod;
  logic [DVD_W-1:0]  dvd;
  logic [QUO_W-1:0]  quo;
  logic [REM_W-1:0]  rem;
  logic              bad;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo_now;
  logic [DVD_W-1:0]   quo_ext;
  logic [DVD_W-1:0]   quo_x400;
  logic [DVD_W-1:0]   quo_x60;
  logic [DVD_W-1:0]   quo_x24;
  logic [YEAR_W-1:0]  y_inc;
  logic [YMOD_W-1:0]  ymod_inc;
  logic               leap_cur;
  logic               leap_nxt;
  logic [DAY_W-1:0]   mlen;
  logic [DAY_W-1:0]   left;
  logic [8:0]         ylen;
  logic               bad_now;

  // quotient by multiplying with a rounded-up reciprocal, exact over each operand range
  always_comb begin
    case (cmd.dsel)
      DIV_400: begin
        mul_a = MUL_A_W'(y[YEAR_W-1:4]);
        mul_b = RECIP_25;
      end
      DIV_24: begin
        mul_a = MUL_A_W'(dvd[DVD_W-1:3]);
        mul_b = RECIP_3;
      end
      DIV_60: begin
        mul_a = dvd[DVD_W-1:2];
        mul_b = RECIP_15;
      end
      default: begin
        mul_a = dvd[DVD_W-1:2];
        mul_b = RECIP_15;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    case (cmd.dsel)
      DIV_400: quo_now = QUO_W'(prod >> SHIFT_25);
      DIV_24:  quo_now = QUO_W'(prod >> SHIFT_3);
      DIV_60:  quo_now = QUO_W'(prod >> SHIFT_15);
      default: quo_now = QUO_W'(prod >> SHIFT_15);
    endcase
  end

  // quotient times divisor by shifts and adds, remainder follows by one subtract
  assign quo_ext  = DVD_W'(quo);
  assign quo_x400 = (quo_ext << 8) + (quo_ext << 7) + (quo_ext << 4);
  assign quo_x60  = (quo_ext << 6) - (quo_ext << 2);
  assign quo_x24  = (quo_ext << 4) + (quo_ext << 3);

  assign y_inc    = y + 1'b1;
  assign ymod_inc = (y == '1 || ymod == YMOD_LAST) ? '0 : ymod + 1'b1;
  assign leap_cur = is_leap(ymod);
  assign leap_nxt = is_leap(ymod_inc);
  assign mlen     = month_len(leap_cur, m);
  assign left     = mlen - d;
  // year from day 1 of month m: the february inside is this year's or next year's
  assign ylen     = ((m <= MON_FEB) ? leap_cur : leap_nxt) ? YLEN_LEAP : YLEN_NORM;

  assign bad_now = (m < MON_JAN) || (m > MON_DEC) || (d == '0) || (d > mlen) ||
                   (hh > LAST_HOUR) || (mi > LAST_MIN) || (ss > SEC_W'(LAST_MIN));

  assign stat.bad        = bad_now;
  assign stat.year_done  = (rem < REM_W'(ylen));
  assign stat.month_done = (rem < REM_W'(mlen));

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        y    <= start_year;
        m    <= start_month;
        d    <= start_day;
        hh   <= start_hour;
        mi   <= start_minute;
        ss   <= start_second;
        days <= add_days & DAYS_MASK;
        secs <= add_seconds;
      end
      OP_DIV_MUL: begin
        quo <= quo_now;
      end
      OP_SET_YMOD: begin
        ymod <= YMOD_W'(DVD_W'(y) - quo_x400);
      end
      OP_START_SEC: begin
        bad <= bad_now;
        dvd <= DVD_W'(ss) + DVD_W'(secs);
      end
      OP_NEXT_MIN: begin
        ss  <= SEC_W'(dvd - quo_x60);
        dvd <= quo_ext + DVD_W'(mi);
      end
      OP_NEXT_HR: begin
        mi  <= MIN_W'(dvd - quo_x60);
        dvd <= quo_ext + DVD_W'(hh);
      end
      OP_FIN_HR: begin
        hh  <= HOUR_W'(dvd - quo_x24);
        rem <= REM_W'(days) + REM_W'(quo);
      end
      OP_PARTIAL: begin
        if (rem != '0 && d != DAY_W'(1)) begin
          if (rem <= REM_W'(left)) begin
            d   <= d + rem[DAY_W-1:0];
            rem <= '0;
          end else begin
            rem <= rem - REM_W'(left) - 1'b1;
            d   <= DAY_W'(1);
            if (m == MON_DEC) begin
              m    <= MON_JAN;
              y    <= y_inc;
              ymod <= ymod_inc;
            end else begin
              m <= m + 1'b1;
            end
          end
        end
      end
      OP_YEAR_STEP: begin
        if (!stat.year_done) begin
          rem  <= rem - REM_W'(ylen);
          y    <= y_inc;
          ymod <= ymod_inc;
        end
      end
      OP_MONTH_STEP: begin
        if (!stat.month_done) begin
          rem <= rem - REM_W'(mlen);
          if (m == MON_DEC) begin
            m    <= MON_JAN;
            y    <= y_inc;
            ymod <= ymod_inc;
          end else begin
            m <= m + 1'b1;
          end
        end
      end
      OP_FINAL: begin
        if (rem != '0) begin
          d <= DAY_W'(1) + rem[DAY_W-1:0];
        end
      end
      OP_OUTPUT: begin
        new_year   <= y;
        new_month  <= m;
        new_day    <= d;
        new_hour   <= hh;
        new_minute <= mi;
        new_second <= ss;
        bad_input  <= bad;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/dtda_ctrl.sv -----
// controller: sequencing state machine and result valid flag
module dtda_ctrl import dtda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dtda_cmd_t  cmd,
  input  dtda_stat_t stat
);

  dtda_state_t      state;
  dtda_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd.op        = OP_NONE;
    cmd.dsel      = DIV_60;
    m_tvalid_next = m_tvalid && !m_tready;
    s_tready      = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          cnt_next   = '0;
          state_next = ST_YMOD;
        end
      end
      ST_YMOD: begin
        cmd.dsel = DIV_400;
        if (cnt != LAST_PHASE) begin
          cmd.op   = OP_DIV_MUL;
          cnt_next = cnt + 1'b1;
        end else begin
          cmd.op     = OP_SET_YMOD;
          cnt_next   = '0;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.op     = OP_START_SEC;
        state_next = stat.bad ? ST_EMIT : ST_SEC;
      end
      ST_SEC: begin
        if (cnt != LAST_PHASE) begin
          cmd.op   = OP_DIV_MUL;
          cnt_next = cnt + 1'b1;
        end else begin
          cmd.op     = OP_NEXT_MIN;
          cnt_next   = '0;
          state_next = ST_MIN;
        end
      end
      ST_MIN: begin
        if (cnt != LAST_PHASE) begin
          cmd.op   = OP_DIV_MUL;
          cnt_next = cnt + 1'b1;
        end else begin
          cmd.op     = OP_NEXT_HR;
          cnt_next   = '0;
          state_next = ST_HR;
        end
      end
      ST_HR: begin
        cmd.dsel = DIV_24;
        if (cnt != LAST_PHASE) begin
          cmd.op   = OP_DIV_MUL;
          cnt_next = cnt + 1'b1;
        end else begin
          cmd.op     = OP_FIN_HR;
          cnt_next   = '0;
          state_next = ST_PART;
        end
      end
      ST_PART: begin
        cmd.op     = OP_PARTIAL;
        state_next = ST_YEAR;
      end
      ST_YEAR: begin
        if (stat.year_done) begin
          state_next = ST_MONTH;
        end else begin
          cmd.op = OP_YEAR_STEP;
        end
      end
      ST_MONTH: begin
        if (stat.month_done) begin
          state_next = ST_FINAL;
        end else begin
          cmd.op = OP_MONTH_STEP;
        end
      end
      ST_FINAL: begin
        cmd.op     = OP_FINAL;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.op        = OP_OUTPUT;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_YMOD))
    else $error("accepted request did not start the year division");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("waiting result dropped before accept");

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0))
    else $error("divide phase not cleared in idle");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUTPUT) |=> (m_tvalid && state == ST_IDLE))
    else $error("result load did not raise valid");
`endif

endmodule

// ----- hw/rtl/datetime_duration_adder.sv -----
// top level of the gregorian date and time adder
// a request runs the year modulo 400 division, the input check, the second, minute and hour
//   divisions, the partial month step, the year walk, the month walk and the final day
//   before the result loads and valid rises; an invalid start is echoed from the check
// requests: one at a time, the next taken the cycle after the result loads;
//   four reciprocal-multiply divisions and the one-year or one-month-per-cycle
//   date walk make up the work on each request
// reset: synchronous rst returns the controller to idle and drops result valid
module datetime_duration_adder import dtda_pkg::*; #(
  parameter int unsigned DAYS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_year, start_month, start_day, start_hour, start_minute, start_second,
  // add_days, add_seconds, zero pad
  input  logic [95:0] s_tdata,
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  // new_year, new_month, new_day, new_hour, new_minute, new_second, zero pad
  output logic [47:0] m_tdata,
  // bad_input
  output logic        m_tuser
);

  dtda_cmd_t  cmd;
  dtda_stat_t stat;

  logic [YEAR_W-1:0] new_year;
  logic [MON_W-1:0]  new_month;
  logic [DAY_W-1:0]  new_day;
  logic [HOUR_W-1:0] new_hour;
  logic [MIN_W-1:0]  new_minute;
  logic [SEC_W-1:0]  new_second;

  // sequencer: one command per cycle to the datapath, holds result valid
  dtda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: request fields unpacked from the low bits up
  dtda_dpath #(
    .DAYS_BITS (DAYS_BITS)
  ) u_dpath (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .start_year   (s_tdata[15:0]),
    .start_month  (s_tdata[19:16]),
    .start_day    (s_tdata[24:20]),
    .start_hour   (s_tdata[29:25]),
    .start_minute (s_tdata[35:30]),
    .start_second (s_tdata[41:36]),
    .add_days     (s_tdata[57:42]),
    .add_seconds  (s_tdata[89:58]),
    .new_year     (new_year),
    .new_month    (new_month),
    .new_day      (new_day),
    .new_hour     (new_hour),
    .new_minute   (new_minute),
    .new_second   (new_second),
    .bad_input    (m_tuser)
  );

  // result fields packed from the low bits up, upper six bits padded with zeros
  assign m_tdata = {6'b0, new_second, new_minute, new_hour, new_day, new_month, new_year};

endmodule
